>>> rtl/kvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants for the key/value text lookup block.
// ----------------------------------------------------------------------------
package kvt_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT = 2'd2;

    localparam logic [15:0] SCAN_LIMIT_RESET = 16'd256;

    // widest value length a job can carry (store depth is at most 64)
    localparam int JOB_LEN_W = 7;

    // characters
    localparam logic [7:0] CH_EQUALS  = 8'h3d;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CASE_BIT   = 8'd32;

    // result job handed from the parser to the emitter
    typedef struct packed {
        logic                 not_found;
        logic                 truncated;
        logic [JOB_LEN_W-1:0] emit;
    } job_t;

    // value store write request (entry index travels beside it)
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] data;
    } store_wr_t;

endpackage
`default_nettype wire

>>> rtl/kvt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_front
// Text parser: key compare, value capture into the store, job generation.
// ----------------------------------------------------------------------------
module kvt_front #(
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_DEPTH = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [kvt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [63:0]                            cfg_wr_data,
    input  wire logic [7:0]                             s_text_byte,
    input  wire logic                                   s_first,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   q_full,
    input  wire logic                                   q_wr_bank,
    output logic                                        job_push,
    output kvt_pkg::job_t                               job,
    output kvt_pkg::store_wr_t                          st_wr,
    output logic [((VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1)-1:0] st_wr_idx
);
    import kvt_pkg::*;

    localparam int IDX_W = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(VALUE_DEPTH + 3);

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_SKIP,
        PH_CAPTURE
    } phase_t;

    // configuration
    logic [63:0] key_chars_reg;
    logic [3:0]  key_length_reg;
    logic [15:0] scan_limit_reg;

    // parser state
    logic [15:0]      pos_reg, pos_next, pos_e;
    phase_t           phase_reg, phase_next, phase_e;
    logic [3:0]       kc_reg, kc_next, kc_e;
    logic             mis_reg, mis_next, mis_e;
    logic [CNT_W-1:0] vc_reg, vc_next, vc_e;
    logic             fin_reg, fin_next, fin_e;

    logic             accept;
    logic             is_letter;
    logic [7:0]       key_byte;
    logic             char_ok;
    logic [CNT_W-1:0] len;
    logic             trunc;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_chars_reg  <= '0;
            key_length_reg <= '0;
            scan_limit_reg <= SCAN_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KEY_CHARS:  key_chars_reg  <= cfg_wr_data;
                CFG_KEY_LENGTH: key_length_reg <= cfg_wr_data[3:0];
                CFG_SCAN_LIMIT: scan_limit_reg <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // state seen by this byte, after a possible restart
    always_comb begin
        pos_e   = s_first ? '0 : pos_reg;
        phase_e = s_first ? PH_SEEK : phase_reg;
        kc_e    = s_first ? '0 : kc_reg;
        mis_e   = s_first ? 1'b0 : mis_reg;
        vc_e    = s_first ? '0 : vc_reg;
        fin_e   = s_first ? 1'b0 : fin_reg;
    end

    // case-insensitive character compare
    always_comb begin
        is_letter = (s_text_byte >= CH_UPPER_A && s_text_byte <= CH_UPPER_Z) ||
                    (s_text_byte >= CH_LOWER_A && s_text_byte <= CH_LOWER_Z);
        key_byte  = (kc_e < 4'(KEY_BYTES)) ? key_chars_reg[{kc_e[2:0], 3'b000} +: 8] : 8'h00;
        char_ok   = (s_text_byte == key_byte) ||
                    (is_letter && ((s_text_byte ^ CASE_BIT) == key_byte));
    end

    // value length without the dropped final byte
    always_comb begin
        len   = (vc_e != '0) ? vc_e - CNT_W'(1) : '0;
        trunc = len > CNT_W'(VALUE_DEPTH);
    end

    // byte handling
    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        kc_next    = kc_reg;
        mis_next   = mis_reg;
        vc_next    = vc_reg;
        fin_next   = fin_reg;
        job_push   = 1'b0;
        job        = '0;
        st_wr      = '0;
        st_wr_idx  = IDX_W'(vc_e);
        st_wr.bank = q_wr_bank;
        st_wr.data = s_text_byte;
        if (accept) begin
            pos_next   = pos_e;
            phase_next = phase_e;
            kc_next    = kc_e;
            mis_next   = mis_e;
            vc_next    = vc_e;
            fin_next   = fin_e;
            if (!fin_e) begin
                if (pos_e >= scan_limit_reg || s_text_byte == CH_NUL) begin
                    job_push      = 1'b1;
                    job.not_found = 1'b1;
                    fin_next      = 1'b1;
                end else begin
                    case (phase_e)
                        PH_CAPTURE: begin
                            if (s_text_byte == CH_NEWLINE) begin
                                job_push      = 1'b1;
                                job.truncated = trunc;
                                job.emit      = trunc ? JOB_LEN_W'(VALUE_DEPTH)
                                                      : JOB_LEN_W'(len);
                                fin_next      = 1'b1;
                            end else begin
                                if (vc_e < CNT_W'(VALUE_DEPTH))
                                    st_wr.en = 1'b1;
                                if (vc_e < CNT_W'(VALUE_DEPTH + 2))
                                    vc_next = vc_e + CNT_W'(1);
                            end
                        end
                        PH_SKIP: begin
                            if (s_text_byte == CH_NEWLINE) begin
                                phase_next = PH_SEEK;
                                kc_next    = '0;
                                mis_next   = 1'b0;
                            end
                        end
                        default: begin
                            if (s_text_byte == CH_EQUALS) begin
                                phase_next = (!mis_e && kc_e == key_length_reg) ?
                                             PH_CAPTURE : PH_SKIP;
                                vc_next    = '0;
                            end else begin
                                if (kc_e >= key_length_reg || !char_ok)
                                    mis_next = 1'b1;
                                if (kc_e != 4'hf)
                                    kc_next = kc_e + 4'd1;
                            end
                        end
                    endcase
                    if (pos_e != 16'hffff)
                        pos_next = pos_e + 16'd1;
                end
            end
        end
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= PH_SEEK;
            kc_reg    <= '0;
            mis_reg   <= 1'b0;
            vc_reg    <= '0;
            fin_reg   <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            kc_reg    <= kc_next;
            mis_reg   <= mis_next;
            vc_reg    <= vc_next;
            fin_reg   <= fin_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/kvt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_queue
// Two-entry job queue; entry slot i owns value store bank i.
// ----------------------------------------------------------------------------
module kvt_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire kvt_pkg::job_t  job_in,
    input  wire logic           pop,
    output kvt_pkg::job_t       job_out,
    output logic                q_valid,
    output logic                q_full,
    output logic                wr_ptr,
    output logic                rd_ptr
);
    import kvt_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign wr_ptr  = wr_ptr_reg;
    assign rd_ptr  = rd_ptr_reg;
    assign q_valid = count_reg != 2'd0;
    assign q_full  = count_reg == 2'd2;
    assign job_out = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (push)
            entry_reg[wr_ptr_reg] <= job_in;
    end

endmodule
`default_nettype wire

>>> rtl/kvt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_back
// Result emitter: two-bank value store, registered read, output register.
// ----------------------------------------------------------------------------
module kvt_back #(
    parameter int VALUE_DEPTH = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire kvt_pkg::store_wr_t                     st_wr,
    input  wire logic [((VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1)-1:0] st_wr_idx,
    input  wire kvt_pkg::job_t                          job,
    input  wire logic                                   q_valid,
    input  wire logic                                   q_rd_bank,
    output logic                                        job_pop,
    output logic                                        m_status,
    output logic [7:0]                                  m_value_byte,
    output logic                                        m_byte_valid,
    output logic                                        m_truncated,
    output logic                                        m_last,
    output logic                                        m_valid,
    input  wire logic                                   m_ready
);
    import kvt_pkg::*;

    localparam int IDX_W  = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
    localparam int ADDR_W = $clog2(2 * VALUE_DEPTH);

    logic [7:0]       mem [2 * VALUE_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             s1_valid_reg;
    logic             s1_status_reg, s1_bvalid_reg, s1_trunc_reg, s1_last_reg;
    logic             out_free, s1_adv, issue, issue_read;
    logic             it_status, it_bvalid, it_last;
    logic             m_valid_reg;

    // bank offsets
    assign wr_addr = st_wr.bank ? ADDR_W'(VALUE_DEPTH) + ADDR_W'(st_wr_idx)
                                : ADDR_W'(st_wr_idx);
    assign rd_addr = q_rd_bank ? ADDR_W'(VALUE_DEPTH) + ADDR_W'(idx_reg)
                               : ADDR_W'(idx_reg);

    // pipeline advance
    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign issue    = q_valid && (!s1_valid_reg || out_free);

    // next item of the head job
    always_comb begin
        it_status  = job.not_found;
        it_bvalid  = 1'b0;
        it_last    = 1'b1;
        issue_read = 1'b0;
        idx_next   = idx_reg;
        if (!job.not_found && job.emit != '0) begin
            it_bvalid = 1'b1;
            it_last   = (JOB_LEN_W'(idx_reg) + JOB_LEN_W'(1)) == job.emit;
            issue_read = issue;
        end
        if (issue)
            idx_next = it_last ? '0 : idx_reg + IDX_W'(1);
        job_pop = issue && it_last;
    end

    // value store
    always_ff @(posedge aclk) begin
        if (st_wr.en)
            mem[wr_addr] <= st_wr.data;
        if (issue_read)
            rd_data_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (issue)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    // item payload through read stage and output register
    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_status_reg <= it_status;
            s1_bvalid_reg <= it_bvalid;
            s1_trunc_reg  <= job.truncated;
            s1_last_reg   <= it_last;
        end
        if (s1_adv) begin
            m_status     <= s1_status_reg;
            m_byte_valid <= s1_bvalid_reg;
            m_truncated  <= s1_trunc_reg;
            m_last       <= s1_last_reg;
            m_value_byte <= s1_bvalid_reg ? rd_data_reg : 8'h00;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

>>> rtl/key_value_text_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_value_text_lookup
// Finds the value of a configured key in a key=value byte stream.
// ----------------------------------------------------------------------------
//  channel  | direction | transfers
//  s_*      | in        | one text byte per transaction (s_text_byte, s_first)
//  m_*      | out       | one result item per transaction (status, value byte, flags)
//  cfg_*    | in        | register write, no response
//
// Input bytes are taken one per cycle while s_ready is high and parsed in that cycle.
// A found value leaves one byte per cycle while m_ready is high, after its newline
// byte, passing through the queue, store read and output register.
// Two finished lookups may be pending; the value store has one bank per
// pending lookup, and s_ready drops while both are taken.
// Reset is synchronous; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module key_value_text_lookup #(
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_DEPTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [kvt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_wr_data,
    input  wire logic [7:0]                    s_text_byte,
    input  wire logic                          s_first,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    output logic                               m_status,
    output logic [7:0]                         m_value_byte,
    output logic                               m_byte_valid,
    output logic                               m_truncated,
    output logic                               m_last,
    output logic                               m_valid,
    input  wire logic                          m_ready
);
    import kvt_pkg::*;

    localparam int IDX_W = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;

    job_t             job_in, job_head;
    store_wr_t        st_wr;
    logic [IDX_W-1:0] st_wr_idx;
    logic             job_push, job_pop;
    logic             q_valid, q_full, wr_ptr, rd_ptr;

    // parser
    kvt_front #(
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_DEPTH (VALUE_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_text_byte (s_text_byte),
        .s_first     (s_first),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .q_full      (q_full),
        .q_wr_bank   (wr_ptr),
        .job_push    (job_push),
        .job         (job_in),
        .st_wr       (st_wr),
        .st_wr_idx   (st_wr_idx)
    );

    // job queue
    kvt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .job_in  (job_in),
        .pop     (job_pop),
        .job_out (job_head),
        .q_valid (q_valid),
        .q_full  (q_full),
        .wr_ptr  (wr_ptr),
        .rd_ptr  (rd_ptr)
    );

    // emitter
    kvt_back #(
        .VALUE_DEPTH (VALUE_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .st_wr        (st_wr),
        .st_wr_idx    (st_wr_idx),
        .job          (job_head),
        .q_valid      (q_valid),
        .q_rd_bank    (rd_ptr),
        .job_pop      (job_pop),
        .m_status     (m_status),
        .m_value_byte (m_value_byte),
        .m_byte_valid (m_byte_valid),
        .m_truncated  (m_truncated),
        .m_last       (m_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule
`default_nettype wire

>>> rtl/kvt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_checker
// Port-level checks on the result channel of the lookup block.
// ----------------------------------------------------------------------------
module kvt_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_status,
    input wire logic [7:0] m_value_byte,
    input wire logic       m_byte_valid,
    input wire logic       m_truncated,
    input wire logic       m_last,
    input wire logic       m_valid,
    input wire logic       m_ready
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_byte) && $stable(m_last))
        else $error("result changed while stalled");

    // empty item carries a zero byte and is the last item
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_value_byte == 8'h00 && m_last)
        else $error("item without value byte is not a zero final item");

    // not-found item shape
    a_nf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_last && !m_byte_valid && !m_truncated)
        else $error("bad not-found item");

    // reset empties the output
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind key_value_text_lookup kvt_checker u_kvt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_status     (m_status),
    .m_value_byte (m_value_byte),
    .m_byte_valid (m_byte_valid),
    .m_truncated  (m_truncated),
    .m_last       (m_last),
    .m_valid      (m_valid),
    .m_ready      (m_ready)
);
`default_nettype wire
